[hdl/bitmap_page_frame_allocator_macros.svh]
// Assertion macros for the page frame allocator RTL.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define BPFA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpfa assertion failed");

// next-cycle implication, disabled in reset
`define BPFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpfa assertion failed");

`endif

[hdl/bpfa_pkg.sv]
// Types, codes and constants of the bitmap page frame allocator.
package bpfa_pkg;

  localparam int unsigned WORD_BITS       = 64;
  localparam int unsigned WORD_LG         = 6;
  localparam int unsigned FRAME_COUNT_DEF = 4096;
  localparam int unsigned INDEX_W         = 12;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REQUEST = 2'd2,
    CMD_MARK    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_TAKEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OP,
    S_SCAN,
    S_DONE
  } state_t;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t unusable;
    word_t taken;
  } map_word_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [INDEX_W-1:0] frame_index;
    logic               usable;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [INDEX_W-1:0] granted_frame;
  } rsp_t;

  typedef struct packed {
    logic               found;
    logic [WORD_LG-1:0] bit_index;
    word_t              onehot;
  } pick_t;

endpackage

[hdl/bpfa_ram.sv]
// Map word memory: one write port, one registered read port.
module bpfa_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  bpfa_pkg::map_word_t wdata,
  input  logic [AW-1:0]       raddr,
  output bpfa_pkg::map_word_t rdata
);
  import bpfa_pkg::*;

  map_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/bpfa_pick.sv]
// Find-first-free unit: lowest usable, untaken frame in one masked map word.
module bpfa_pick (
  input  bpfa_pkg::map_word_t word,
  input  bpfa_pkg::word_t     mask,
  output bpfa_pkg::pick_t     pick
);
  import bpfa_pkg::*;

  word_t              avail;
  word_t              onehot;
  logic [WORD_LG-1:0] idx;

  always_comb begin
    avail  = ~word.unusable & ~word.taken & mask;
    onehot = avail & (~avail + word_t'(1));
    idx    = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (onehot[i]) begin
        idx = idx | WORD_LG'(i);
      end
    end
    pick.found     = |avail;
    pick.bit_index = idx;
    pick.onehot    = onehot;
  end

endmodule

[hdl/bitmap_page_frame_allocator.sv]
// Top level: bitmap next-fit page frame allocator with sequencer.
//
// Usage: commands enter on req (valid/ready), one result per command leaves on
// rsp (valid/ready). Commands: allocate, free, request a given frame, mark a
// frame usable or unusable. Both maps live in one memory of 64-frame words.
// Reset starts a clearing pass over every map word that marks every frame
// unusable and not taken; req_ready is low until it ends.
// Free, request and mark: one word read, modify and write; the result goes
// through S_OP and S_DONE into the rsp register before the next command is
// taken.
// Allocate: one map word per cycle goes through the find-first unit, starting
// at the word of the last grant and wrapping back to its low bits; its run
// time is set by how many words are read before a free frame turns up.
// One command is in work at a time. The result register frees the sequencer
// from the receiver: a new command may be taken while a result waits, but a
// finished command holds in its last step until the result register is free.
module bitmap_page_frame_allocator #(
  parameter int unsigned FRAME_COUNT = bpfa_pkg::FRAME_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bpfa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output bpfa_pkg::rsp_t rsp
);
  import bpfa_pkg::*;

  localparam int unsigned WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned IW    = WAW + WORD_LG;
  localparam int unsigned KW    = $clog2(WORDS + 1);

  state_t             state;
  state_t             state_next;
  logic [WAW-1:0]     clr_cnt;
  logic [WAW-1:0]     rd_word;
  logic [WAW-1:0]     ev_word;
  logic [KW-1:0]      ev_k;
  cmd_t               op_cmd;
  logic [WORD_LG-1:0] op_bit;
  logic               op_fits;
  logic               op_usable;
  logic [INDEX_W-1:0] last;
  rsp_t               res;

  logic               ram_we;
  logic [WAW-1:0]     ram_waddr;
  map_word_t          ram_wdata;
  logic [WAW-1:0]     ram_raddr;
  map_word_t          ram_rdata;
  word_t              mask;
  pick_t              pick;

  logic [IW-1:0]      req_frame;
  logic [IW-1:0]      start_frame;
  logic [WAW-1:0]     start_word;
  logic [WAW-1:0]     start_word_inc;
  logic [WAW-1:0]     rd_word_inc;
  logic               req_fits;
  logic               accept;
  logic               scan_end;
  logic               alloc_hit;
  logic               res_load;
  rsp_t               res_next;
  logic               rsp_free;
  word_t              ge_mask;
  word_t              sel;

  bpfa_ram #(
    .DEPTH (WORDS),
    .AW    (WAW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bpfa_pick u_pick (
    .word (ram_rdata),
    .mask (mask),
    .pick (pick)
  );

  assign req_frame      = IW'(req.frame_index);
  assign start_frame    = IW'(last);
  assign start_word     = start_frame[IW-1:WORD_LG];
  assign start_word_inc = (start_word == WAW'(WORDS - 1)) ? '0 : start_word + 1'b1;
  assign rd_word_inc    = (rd_word == WAW'(WORDS - 1)) ? '0 : rd_word + 1'b1;
  assign req_fits       = 32'(req.frame_index) < 32'(FRAME_COUNT);
  assign accept         = req_valid && req_ready;
  assign rsp_free       = !rsp_valid || rsp_ready;
  assign ge_mask        = {WORD_BITS{1'b1}} << op_bit;
  assign sel            = word_t'(1) << op_bit;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == WAW'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          state_next = (req.cmd == CMD_ALLOC) ? S_SCAN : S_OP;
        end
      end
      S_OP: begin
        state_next = S_DONE;
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // datapath control
  always_comb begin
    req_ready  = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = ev_word;
    ram_wdata  = ram_rdata;
    ram_raddr  = rd_word;
    mask       = '1;
    scan_end   = 1'b0;
    alloc_hit  = 1'b0;
    res_load   = 1'b0;
    res_next.status        = ST_OK;
    res_next.granted_frame = '0;
    case (state)
      S_CLEAR: begin
        ram_we             = 1'b1;
        ram_waddr          = clr_cnt;
        ram_wdata.unusable = '1;
        ram_wdata.taken    = '0;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        ram_raddr = (req.cmd == CMD_ALLOC) ? start_word : req_frame[IW-1:WORD_LG];
      end
      S_OP: begin
        res_load = 1'b1;
        case (op_cmd)
          CMD_FREE: begin
            ram_we          = op_fits;
            ram_wdata.taken = ram_rdata.taken & ~sel;
          end
          CMD_REQUEST: begin
            if (op_fits && ((ram_rdata.taken & sel) == '0)) begin
              ram_we          = 1'b1;
              ram_wdata.taken = ram_rdata.taken | sel;
            end else begin
              res_next.status = ST_TAKEN;
            end
          end
          CMD_MARK: begin
            ram_we             = op_fits;
            ram_wdata.unusable = op_usable ? (ram_rdata.unusable & ~sel)
                                           : (ram_rdata.unusable | sel);
          end
          default: begin
            ram_we = 1'b0;
          end
        endcase
      end
      S_SCAN: begin
        if (ev_k == '0) begin
          mask = ge_mask;
        end else if (ev_k == KW'(WORDS)) begin
          mask = ~ge_mask;
        end
        scan_end = pick.found || (ev_k == KW'(WORDS));
        res_load = scan_end;
        if (pick.found) begin
          alloc_hit              = 1'b1;
          ram_we                 = 1'b1;
          ram_wdata.taken        = ram_rdata.taken | pick.onehot;
          res_next.granted_frame = INDEX_W'({ev_word, pick.bit_index});
        end else begin
          res_next.status = ST_OOM;
        end
      end
      S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_cnt   <= '0;
      last      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (alloc_hit) begin
        last <= res_next.granted_frame;
      end
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_cmd    <= req.cmd;
      op_fits   <= req_fits;
      op_usable <= req.usable;
      ev_k      <= '0;
      if (req.cmd == CMD_ALLOC) begin
        ev_word <= start_word;
        rd_word <= start_word_inc;
        op_bit  <= start_frame[WORD_LG-1:0];
      end else begin
        ev_word <= req_frame[IW-1:WORD_LG];
        op_bit  <= req_frame[WORD_LG-1:0];
      end
    end else if (state == S_SCAN) begin
      ev_word <= rd_word;
      rd_word <= rd_word_inc;
      ev_k    <= ev_k + 1'b1;
    end
    if (res_load) begin
      res <= res_next;
    end
    if (state == S_DONE && rsp_free) begin
      rsp <= res;
    end
  end

`include "bitmap_page_frame_allocator_macros.svh"

  `BPFA_ASSERT_NOW(a_rsp_from_done, clk, rst, $rose(rsp_valid), $past(state) == S_DONE)
  `BPFA_ASSERT_NOW(a_grant_in_range, clk, rst, rsp_valid && rsp.status == ST_OK, 32'(rsp.granted_frame) < 32'(FRAME_COUNT))
  `BPFA_ASSERT_NOW(a_scan_one_bit, clk, rst, state == S_SCAN && ram_we, $onehot(pick.onehot))
  `BPFA_ASSERT_NOW(a_scan_bounded, clk, rst, state == S_SCAN, ev_k <= KW'(WORDS))
  `BPFA_ASSERT_NEXT(a_scan_done, clk, rst, state == S_SCAN && scan_end, state == S_DONE)

endmodule

[dv/tb_bitmap_page_frame_allocator.sv]
// Self-checking testbench for the bitmap next-fit page frame allocator.
`timescale 1ns / 1ps

module tb_bitmap_page_frame_allocator;
  import bpfa_pkg::*;

  localparam int FRAMES     = FRAME_COUNT_DEF;
  localparam int RAND_ITEMS = 527;
  localparam int HOLD_CYC   = 300;
  localparam int DRAIN_CYC  = 80;
  localparam int STALL_MAX  = 3000;
  localparam int DIR_ROWS   = 23;

  typedef struct packed {
    req_t in;
    logic chk;
    rsp_t want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  logic cur_chk = 1'b0;
  rsp_t cur_want = '0;
  bit hold_rsp = 1'b0;
  bit calm = 1'b0;

  bit unusable_map [FRAMES];
  bit taken_map [FRAMES];
  logic [INDEX_W-1:0] last_grant;
  rsp_t pending_rsp [$];
  int err_count = 0;
  int rsp_count = 0;

  // directed rows: typed results where obvious, predictor elsewhere
  step_t dir_plan [DIR_ROWS] = '{
    '{'{CMD_ALLOC,   12'd0,    1'b0}, 1'b1, '{ST_OOM,   12'd0}},
    '{'{CMD_REQUEST, 12'd0,    1'b0}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_REQUEST, 12'd0,    1'b1}, 1'b1, '{ST_TAKEN, 12'd0}},
    '{'{CMD_REQUEST, 12'd4095, 1'b1}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_FREE,    12'd4095, 1'b0}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_FREE,    12'd4095, 1'b0}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_MARK,    12'd4095, 1'b1}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_ALLOC,   12'd0,    1'b0}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_ALLOC,   12'd4095, 1'b1}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_MARK,    12'd0,    1'b1}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_FREE,    12'd0,    1'b1}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_MARK,    12'hAAA,  1'b1}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_MARK,    12'h555,  1'b1}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_ALLOC,   12'd0,    1'b0}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_ALLOC,   12'd0,    1'b0}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_ALLOC,   12'd0,    1'b0}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_MARK,    12'h555,  1'b0}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_FREE,    12'h555,  1'b0}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_ALLOC,   12'd0,    1'b0}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_REQUEST, 12'h555,  1'b0}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_FREE,    12'd4095, 1'b1}, 1'b1, '{ST_OK,    12'd0}},
    '{'{CMD_ALLOC,   12'd0,    1'b1}, 1'b0, '{ST_OK,    12'd0}},
    '{'{CMD_MARK,    12'd4095, 1'b0}, 1'b1, '{ST_OK,    12'd0}}
  };

  bitmap_page_frame_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #4 clk = ~clk;

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
  end

  // next-fit allocator state update, one command per call
  function automatic rsp_t predict_frame_op(req_t r);
    rsp_t res;
    int start;
    int idx;
    bit found;
    res = '{ST_OK, '0};
    found = 1'b0;
    start = int'(last_grant);
    case (r.cmd)
      CMD_ALLOC: begin
        for (int n = 0; n < FRAMES && !found; n++) begin
          idx = (start + n) % FRAMES;
          if (!unusable_map[idx] && !taken_map[idx]) begin
            found = 1'b1;
            res.granted_frame = idx[INDEX_W-1:0];
          end
        end
        if (found) begin
          taken_map[res.granted_frame] = 1'b1;
          last_grant = res.granted_frame;
        end else begin
          res.status = ST_OOM;
        end
      end
      CMD_FREE: taken_map[r.frame_index] = 1'b0;
      CMD_REQUEST: begin
        if (!taken_map[r.frame_index]) taken_map[r.frame_index] = 1'b1;
        else res.status = ST_TAKEN;
      end
      default: unusable_map[r.frame_index] = ~r.usable;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s at result %0d: got %0d expected %0d", what, rsp_count, got, want);
    err_count++;
  endtask

  // hot frame windows keep the usable set small so allocation runs dry
  function automatic logic [INDEX_W-1:0] pick_frame();
    int base;
    if ($urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 2))
        0: base = 0;
        1: base = 2040;
        default: base = 4088;
      endcase
      return INDEX_W'(base + $urandom_range(0, 7));
    end
    return INDEX_W'($urandom_range(0, FRAMES - 1));
  endfunction

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      unusable_map[i] = 1'b1;
      taken_map[i] = 1'b0;
    end
    last_grant = '0;
  end

  // transfer monitor and checker
  always @(posedge clk) begin
    rsp_t want;
    rsp_t got;
    if (!rst) begin
      if (req_valid && req_ready) begin
        want = predict_frame_op(req);
        pending_rsp.push_back(cur_chk ? cur_want : want);
      end
      if (rsp_valid && rsp_ready) begin
        got = rsp;
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected result, status", int'(got.status), -1);
        end else begin
          want = pending_rsp.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", int'(got.status), int'(want.status));
          if (got.granted_frame !== want.granted_frame)
            report_mismatch("granted_frame", int'(got.granted_frame),
                            int'(want.granted_frame));
        end
        rsp_count++;
      end
    end
  end

  task automatic send_item(input step_t s);
    if (!calm && $urandom_range(0, 99) < 13) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 13);
    end
    req <= s.in;
    cur_chk <= s.chk;
    cur_want <= s.want;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  initial begin
    step_t s;
    int r;
    while (rst) @(negedge clk);
    for (int i = 0; i < DIR_ROWS; i++) send_item(dir_plan[i]);
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 100) hold_rsp = 1'b1;
      if (n == 250) begin
        req_valid <= 1'b0;
        do @(negedge clk); while (pending_rsp.size() != 0);
      end
      calm = (n >= 350 && n < 450);
      s = '0;
      s.in.frame_index = pick_frame();
      s.in.usable = $urandom_range(0, 3) != 0;
      r = $urandom_range(0, 99);
      if (r < 35) s.in.cmd = CMD_ALLOC;
      else if (r < 55) s.in.cmd = CMD_FREE;
      else if (r < 70) s.in.cmd = CMD_REQUEST;
      else s.in.cmd = CMD_MARK;
      send_item(s);
    end
    req_valid <= 1'b0;
    do @(negedge clk); while (pending_rsp.size() != 0);
    repeat (DRAIN_CYC) @(negedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver: random backpressure, one long hold-off on request
  initial begin
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_rsp = 1'b0;
      end else begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= 13);
      end
    end
  end

  initial begin
    int stall_cyc;
    stall_cyc = 0;
    while (stall_cyc < STALL_MAX) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cyc = 0;
      else stall_cyc++;
    end
    $display("watchdog: no transfer for %0d cycles", STALL_MAX);
    $display("FAIL");
    $finish;
  end

endmodule
